// ----- hw/rtl/iida_pkg.sv -----
// Shared types and constants for the indexed insert/delete array.
// Holds request and status codes and the command struct broadcast to the cells.
// No dependencies.
package iida_pkg;

    // Default sizing
    localparam int CAPACITY_DEF  = 64;
    localparam int WORD_BITS_DEF = 64;

    // Fixed port widths
    localparam int WORD_PORT_W = 64;
    localparam int FIELD_W     = 7;

    // Width of position and count values inside the array, sized for the largest capacity
    localparam int CAPACITY_MAX = 1024;
    localparam int CNT_MAX_W    = $clog2(CAPACITY_MAX + 1);

    // Request codes
    typedef enum logic [2:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_TRUNC  = 3'd3,
        REQ_READ   = 3'd4
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Per-cycle cell operation
    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_APPEND = 3'd1,
        OP_INSERT = 3'd2,
        OP_REMOVE = 3'd3,
        OP_TRUNC  = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    // Command broadcast to every cell.
    // pos: insert/remove/read position, or the new count for a truncation.
    // cnt: entry count before the request.
    typedef struct packed {
        op_t                  op;
        logic [CNT_MAX_W-1:0] pos;
        logic [CNT_MAX_W-1:0] cnt;
    } cmd_t;

endpackage

// ----- hw/rtl/indexed_insert_delete_array.sv -----
// Top level of the indexed insert/delete array: request decode, cell row, result register.
// Depends on iida_pkg and iida_cell.
//
// Usage:
//   Request channel (in_valid/in_ready) carries req_type, word_in, position and
//   drop_count; result channel (out_valid/out_ready) carries status, word_out and
//   entry_count. Every request yields exactly one result word.
//   The array is a row of cells, one per entry. An accepted request updates all
//   cells at the same clock edge (shift up on insert, shift down on remove, clear
//   on truncate), so the block accepts one word per cycle while its result is taken.
//   The result is in the output register from the cycle after accept.
//   A read selects the addressed cell through an OR tree across the row.
//   When the receiver stalls, the result is held and in_ready drops until it is
//   taken; a new request is accepted in the same cycle the old result leaves.
//   Reset clears all entries and the count to zero and empties the output register.
//   Refused requests (full, bad index, unused code) leave the array unchanged.
module indexed_insert_delete_array #(
    parameter int CAPACITY  = iida_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [2:0]                       req_type,
    input  logic [iida_pkg::WORD_PORT_W-1:0] word_in,
    input  logic [iida_pkg::FIELD_W-1:0]     position,
    input  logic [iida_pkg::FIELD_W-1:0]     drop_count,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [iida_pkg::WORD_PORT_W-1:0] word_out,
    output logic [iida_pkg::FIELD_W-1:0]     entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = iida_pkg::CNT_MAX_W;
    localparam logic [CW-1:0] CAP_X = CW'(CAPACITY);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    iida_pkg::status_t                status_reg;
    logic [iida_pkg::WORD_PORT_W-1:0] word_out_reg;
    logic [iida_pkg::FIELD_W-1:0]     count_out_reg;

    logic                 fire;
    logic [CW-1:0]        cnt_x;
    logic [CW-1:0]        pos_x;
    logic [CW-1:0]        drop_x;
    logic [CW-1:0]        new_cnt;
    logic                 is_full;
    iida_pkg::op_t        op_sel;
    iida_pkg::status_t    st_sel;
    iida_pkg::cmd_t       cmd;
    logic [WORD_BITS-1:0] word_m;
    logic [WORD_BITS-1:0] rd_word;

    logic [WORD_BITS-1:0] ent   [CAPACITY];
    logic [WORD_BITS-1:0] lower [CAPACITY];
    logic [WORD_BITS-1:0] upper [CAPACITY];
    logic [WORD_BITS-1:0] rpart [CAPACITY];

    // Handshake: accept when the result register is free or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    assign cnt_x  = CW'(cnt_reg);
    assign pos_x  = CW'(position);
    assign drop_x = CW'(drop_count);
    assign word_m = word_in[WORD_BITS-1:0];
    assign is_full = (cnt_x >= CAP_X);

    // Decode the request into a cell operation, status and new count
    always_comb
    begin
        op_sel  = iida_pkg::OP_NONE;
        st_sel  = iida_pkg::ST_DONE;
        new_cnt = cnt_x;
        cmd.pos = pos_x;
        unique case (req_type)
            iida_pkg::REQ_APPEND:
            begin
                if (is_full)
                    st_sel = iida_pkg::ST_FULL;
                else
                begin
                    op_sel  = iida_pkg::OP_APPEND;
                    new_cnt = cnt_x + CW'(1);
                end
            end
            iida_pkg::REQ_INSERT:
            begin
                if (pos_x > cnt_x)
                    st_sel = iida_pkg::ST_RANGE;
                else if (is_full)
                    st_sel = iida_pkg::ST_FULL;
                else
                begin
                    op_sel  = iida_pkg::OP_INSERT;
                    new_cnt = cnt_x + CW'(1);
                end
            end
            iida_pkg::REQ_REMOVE:
            begin
                if (pos_x >= cnt_x)
                    st_sel = iida_pkg::ST_RANGE;
                else
                begin
                    op_sel  = iida_pkg::OP_REMOVE;
                    new_cnt = cnt_x - CW'(1);
                end
            end
            iida_pkg::REQ_TRUNC:
            begin
                if (drop_x > cnt_x)
                    st_sel = iida_pkg::ST_RANGE;
                else
                begin
                    op_sel  = iida_pkg::OP_TRUNC;
                    new_cnt = cnt_x - drop_x;
                    cmd.pos = cnt_x - drop_x;
                end
            end
            iida_pkg::REQ_READ:
            begin
                if (pos_x >= cnt_x)
                    st_sel = iida_pkg::ST_RANGE;
                else
                    op_sel = iida_pkg::OP_READ;
            end
            default:
            begin
                st_sel = iida_pkg::ST_RANGE;
            end
        endcase
        cmd.op  = fire ? op_sel : iida_pkg::OP_NONE;
        cmd.cnt = cnt_x;
    end

    // Row of cells, each wired to its neighbors
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign lower[gi] = '0;
            end
            else
            begin : g_mid_lo
                assign lower[gi] = ent[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign upper[gi] = '0;
            end
            else
            begin : g_mid_hi
                assign upper[gi] = ent[gi+1];
            end

            iida_cell #(
                .WORD_BITS (WORD_BITS),
                .IDX       (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .word_in   (word_m),
                .lower_in  (lower[gi]),
                .upper_in  (upper[gi]),
                .entry     (ent[gi]),
                .read_part (rpart[gi])
            );
        end
    endgenerate

    // Collect the addressed entry; at most one cell drives a nonzero word
    always_comb
    begin
        rd_word = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_word = rd_word | rpart[k];
    end

    // Advance the count on accept
    assign cnt_next = fire ? new_cnt[CNT_W-1:0] : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // Result register: load on accept, drop when taken
    assign out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= st_sel;
            word_out_reg  <= iida_pkg::WORD_PORT_W'(rd_word);
            count_out_reg <= new_cnt[iida_pkg::FIELD_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign word_out    = word_out_reg;
    assign entry_count = count_out_reg;

    // Count never passes capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // Count moves only on an accepted word
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(cnt_reg))
        else $error("entry count changed without a request");

    // Every accepted word produces a pending result
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("accepted request left no result");

    // A full status is only reported with the array at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == iida_pkg::ST_FULL) |-> (cnt_reg == CNT_W'(CAPACITY)))
        else $error("full status with room left");

endmodule

// ----- hw/rtl/iida_cell.sv -----
// One storage cell of the indexed insert/delete array.
// Holds one entry, takes from its lower or upper neighbor on insert/remove.
// Depends on iida_pkg.
module iida_cell #(
    parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  iida_pkg::cmd_t       cmd,
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [WORD_BITS-1:0] lower_in,
    input  logic [WORD_BITS-1:0] upper_in,
    output logic [WORD_BITS-1:0] entry,
    output logic [WORD_BITS-1:0] read_part
);

    localparam logic [iida_pkg::CNT_MAX_W-1:0] MY_IDX  = iida_pkg::CNT_MAX_W'(IDX);
    localparam logic [iida_pkg::CNT_MAX_W-1:0] MY_NEXT = iida_pkg::CNT_MAX_W'(IDX + 1);

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;

    // Decide this cell's move from the broadcast command
    always_comb
    begin
        entry_next = entry_reg;
        unique case (cmd.op)
            iida_pkg::OP_APPEND:
            begin
                if (MY_IDX == cmd.cnt)
                    entry_next = word_in;
            end
            iida_pkg::OP_INSERT:
            begin
                if (MY_IDX == cmd.pos)
                    entry_next = word_in;
                else if (MY_IDX > cmd.pos && MY_IDX <= cmd.cnt)
                    entry_next = lower_in;
            end
            iida_pkg::OP_REMOVE:
            begin
                if (MY_IDX >= cmd.pos && MY_NEXT < cmd.cnt)
                    entry_next = upper_in;
                else if (MY_NEXT == cmd.cnt)
                    entry_next = '0;
            end
            iida_pkg::OP_TRUNC:
            begin
                if (MY_IDX >= cmd.pos)
                    entry_next = '0;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign entry = entry_reg;

    // Drive the entry onto the read OR tree when addressed
    assign read_part = (cmd.op == iida_pkg::OP_READ && MY_IDX == cmd.pos) ? entry_reg : '0;

endmodule

// ----- bench/iida_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the indexed insert/delete array bench: watches both channels,
// keeps a shadow copy of the array and compares every result word field by field.
// Depends on iida_pkg.
module iida_result_checker #(
    parameter int CAPACITY  = iida_pkg::CAPACITY_DEF,
    parameter int WORD_BITS = iida_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [2:0]                       req_type,
    input  logic [iida_pkg::WORD_PORT_W-1:0] word_in,
    input  logic [iida_pkg::FIELD_W-1:0]     position,
    input  logic [iida_pkg::FIELD_W-1:0]     drop_count,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [1:0]                       status,
    input  logic [iida_pkg::WORD_PORT_W-1:0] word_out,
    input  logic [iida_pkg::FIELD_W-1:0]     entry_count,
    output int                               fail_count,
    output int                               replies_waiting,
    output int                               replies_checked,
    output logic [iida_pkg::FIELD_W-1:0]     fill_level
);
    import iida_pkg::*;

    localparam logic [WORD_PORT_W-1:0] WORD_MASK =
        {WORD_PORT_W{1'b1}} >> (WORD_PORT_W - WORD_BITS);

    typedef struct packed {
        status_t                st;
        logic [WORD_PORT_W-1:0] word;
        logic [FIELD_W-1:0]     count;
    } array_reply_t;

    array_reply_t           replies_due[$];
    logic [WORD_PORT_W-1:0] shadow [CAPACITY];
    int unsigned            shadow_fill;
    int                     errors;
    int                     checked;

    // Apply one request to the shadow array and return the reply it should give
    function automatic array_reply_t apply_request(
        input logic [2:0]             kind,
        input logic [WORD_PORT_W-1:0] word,
        input logic [FIELD_W-1:0]     pos,
        input logic [FIELD_W-1:0]     drop
    );
        array_reply_t reply;
        int unsigned  p;
        int unsigned  n;
        int unsigned  k;
        reply.st   = ST_DONE;
        reply.word = '0;
        p = 32'(pos);
        n = 32'(drop);
        case (kind)
            REQ_APPEND:
            begin
                if (shadow_fill >= CAPACITY)
                    reply.st = ST_FULL;
                else
                begin
                    shadow[shadow_fill] = word & WORD_MASK;
                    shadow_fill++;
                end
            end
            REQ_INSERT:
            begin
                // range check wins over the full check
                if (p > shadow_fill)
                    reply.st = ST_RANGE;
                else if (shadow_fill >= CAPACITY)
                    reply.st = ST_FULL;
                else
                begin
                    for (k = shadow_fill; k > p; k--)
                        shadow[k] = shadow[k - 1];
                    shadow[p] = word & WORD_MASK;
                    shadow_fill++;
                end
            end
            REQ_REMOVE:
            begin
                if (p >= shadow_fill)
                    reply.st = ST_RANGE;
                else
                begin
                    for (k = p; k + 1 < shadow_fill; k++)
                        shadow[k] = shadow[k + 1];
                    shadow_fill--;
                    shadow[shadow_fill] = '0;
                end
            end
            REQ_TRUNC:
            begin
                if (n > shadow_fill)
                    reply.st = ST_RANGE;
                else
                begin
                    for (k = 0; k < n; k++)
                        shadow[shadow_fill - 1 - k] = '0;
                    shadow_fill -= n;
                end
            end
            REQ_READ:
            begin
                if (p >= shadow_fill)
                    reply.st = ST_RANGE;
                else
                    reply.word = shadow[p];
            end
            default:
                reply.st = ST_RANGE;
        endcase
        reply.count = FIELD_W'(shadow_fill);
        return reply;
    endfunction

    // Compare the outgoing word first, then predict the incoming one
    always @(posedge clk or negedge rst_n)
    begin : track
        array_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                shadow[i] = '0;
            shadow_fill = 0;
            replies_due.delete();
            errors  = 0;
            checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: unexpected result word: expected none, got status=%0d word=%h count=%0d",
                             $time, status, word_out, entry_count);
                    errors++;
                end
                else
                begin
                    want = replies_due.pop_front();
                    checked++;
                    if (status !== want.st)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.st, status);
                        errors++;
                    end
                    if (word_out !== want.word)
                    begin
                        $display("%0t: word_out mismatch: expected %h, got %h",
                                 $time, want.word, word_out);
                        errors++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d, got %0d",
                                 $time, want.count, entry_count);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                replies_due.push_back(apply_request(req_type, word_in, position, drop_count));
        end
        // Publish after the edge so readers see a settled value
        fail_count      <= errors;
        replies_waiting <= replies_due.size();
        replies_checked <= checked;
        fill_level      <= FIELD_W'(shadow_fill);
    end

endmodule

// ----- bench/indexed_insert_delete_array_tb.sv -----
`timescale 1ns / 100ps
// Top of the indexed insert/delete array bench: clock, reset, request and result
// traffic, watchdog and verdict. Depends on iida_pkg, the block and iida_result_checker.
module indexed_insert_delete_array_tb;
    import iida_pkg::*;

    localparam int CAPACITY       = 64;
    localparam int WORD_BITS      = 64;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int FIRST_EPISODE  = 150;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_OFF_LEN   = 200;
    localparam int QUIET_FROM     = 800;
    localparam int QUIET_TO       = 1100;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 1000;

    // Request codes the block does not define
    localparam logic [2:0] FIRST_SPARE_REQ = 3'd5;
    localparam logic [2:0] LAST_SPARE_REQ  = 3'd7;

    localparam logic [WORD_PORT_W-1:0] ALL_ONES = {WORD_PORT_W{1'b1}};
    localparam logic [FIELD_W-1:0]     MAX_FIELD = {FIELD_W{1'b1}};

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_BALANCED
    } traffic_mix_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [2:0]             req_type;
    logic [WORD_PORT_W-1:0] word_in;
    logic [FIELD_W-1:0]     position;
    logic [FIELD_W-1:0]     drop_count;
    logic                   out_valid;
    logic                   out_ready;
    logic [1:0]             status;
    logic [WORD_PORT_W-1:0] word_out;
    logic [FIELD_W-1:0]     entry_count;

    int                     fail_count;
    int                     replies_waiting;
    int                     replies_checked;
    logic [FIELD_W-1:0]     fill_level;

    logic                   quiet;
    int                     hold_off_cycles;
    int                     hold_len;
    int                     stall_cycles;
    int                     kind_sent [8];

    indexed_insert_delete_array #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .word_in     (word_in),
        .position    (position),
        .drop_count  (drop_count),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .word_out    (word_out),
        .entry_count (entry_count)
    );

    iida_result_checker #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .req_type        (req_type),
        .word_in         (word_in),
        .position        (position),
        .drop_count      (drop_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .word_out        (word_out),
        .entry_count     (entry_count),
        .fail_count      (fail_count),
        .replies_waiting (replies_waiting),
        .replies_checked (replies_checked),
        .fill_level      (fill_level)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one request word, with random idle cycles ahead of it, and hold it until taken
    task automatic offer_request(
        input logic [2:0]             kind,
        input logic [WORD_PORT_W-1:0] word,
        input logic [FIELD_W-1:0]     pos,
        input logic [FIELD_W-1:0]     drop
    );
        while (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        word_in    <= word;
        position   <= pos;
        drop_count <= drop;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        kind_sent[kind]++;
    endtask

    function automatic logic [WORD_PORT_W-1:0] pick_word();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return ALL_ONES;
        else if (r < 20)
            return '0;
        return {$urandom, $urandom};
    endfunction

    // Positions cluster around the current count, where the boundaries are
    function automatic logic [FIELD_W-1:0] pick_index(input int level);
        int r;
        int p;
        r = $urandom_range(99);
        if (r < 55)
            p = int'($urandom_range(level, 0));
        else if (r < 80)
            p = level + int'($urandom_range(2)) - 1;
        else if (r < 90)
            p = 0;
        else
            p = int'($urandom_range(127));
        if (p < 0)
            p = 0;
        return FIELD_W'(p);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_drop(input int level);
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 45)
            n = int'($urandom_range(3));
        else if (r < 65)
            n = level;
        else if (r < 75)
            n = level + 1;
        else if (r < 88)
            n = int'($urandom_range(level, 0));
        else
            n = int'($urandom_range(127));
        return FIELD_W'(n);
    endfunction

    // Draw one request, weighted by the traffic mix
    task automatic random_request(input traffic_mix_t mix);
        int         r;
        int         level;
        int         lim_app;
        int         lim_ins;
        int         lim_rd;
        int         lim_rm;
        int         lim_tr;
        logic [2:0] kind;
        level = int'(fill_level);
        case (mix)
            MIX_GROW:
            begin
                lim_app = 45; lim_ins = 80; lim_rd = 87; lim_rm = 93; lim_tr = 98;
            end
            MIX_SHRINK:
            begin
                lim_app = 5; lim_ins = 15; lim_rd = 35; lim_rm = 70; lim_tr = 97;
            end
            default:
            begin
                lim_app = 22; lim_ins = 42; lim_rd = 62; lim_rm = 80; lim_tr = 96;
            end
        endcase
        r = $urandom_range(99);
        if (r < lim_app)
            kind = REQ_APPEND;
        else if (r < lim_ins)
            kind = REQ_INSERT;
        else if (r < lim_rd)
            kind = REQ_READ;
        else if (r < lim_rm)
            kind = REQ_REMOVE;
        else if (r < lim_tr)
            kind = REQ_TRUNC;
        else
            kind = 3'($urandom_range(LAST_SPARE_REQ, FIRST_SPARE_REQ));
        offer_request(kind, pick_word(), pick_index(level), pick_drop(level));
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready       <= 1'b0;
                hold_len        = hold_off_cycles;
                hold_off_cycles <= 0;
                repeat (hold_len - 1)
                    @(posedge clk);
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long
    initial
        stall_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, replies_waiting);
            $display("TB_ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int           n;
        int           episode_left;
        traffic_mix_t mix;

        for (int i = 0; i < 8; i++)
            kind_sent[i] = 0;
        in_valid        <= 1'b0;
        req_type        <= REQ_APPEND;
        word_in         <= '0;
        position        <= '0;
        drop_count      <= '0;
        quiet           <= 1'b0;
        hold_off_cycles <= 0;
        rst_n           <= 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty array: every index is out of range, dropping nothing succeeds
        offer_request(REQ_READ,   '0, 7'd0, 7'd0);
        offer_request(REQ_REMOVE, '0, 7'd0, 7'd0);
        offer_request(REQ_TRUNC,  '0, 7'd0, 7'd0);
        offer_request(REQ_TRUNC,  '0, 7'd0, 7'd1);
        offer_request(REQ_INSERT, ALL_ONES, 7'd1, 7'd0);
        // Build three entries: append, insert at front, insert at the end; an insert past the end is refused
        offer_request(REQ_APPEND, ALL_ONES, 7'd0, 7'd0);
        offer_request(REQ_INSERT, '0, 7'd0, 7'd0);
        offer_request(REQ_INSERT, 64'h5a5a_a5a5_0f0f_f0f0, 7'd2, 7'd0);
        offer_request(REQ_INSERT, 64'h1234_5678_9abc_def0, 7'd4, 7'd0);
        // Reads at both ends and one past the end
        offer_request(REQ_READ,   '0, 7'd0, 7'd0);
        offer_request(REQ_READ,   '0, 7'd2, 7'd0);
        offer_request(REQ_READ,   '0, 7'd3, 7'd0);
        // Remove at the count is refused, remove from the middle shifts down
        offer_request(REQ_REMOVE, '0, 7'd3, 7'd0);
        offer_request(REQ_REMOVE, '0, 7'd1, 7'd0);
        offer_request(REQ_READ,   '0, 7'd1, 7'd0);
        // Spare request codes, two with every field bit set and one with all fields zero
        offer_request(FIRST_SPARE_REQ, ALL_ONES, MAX_FIELD, MAX_FIELD);
        offer_request(3'(FIRST_SPARE_REQ + 3'd1), ALL_ONES, MAX_FIELD, MAX_FIELD);
        offer_request(LAST_SPARE_REQ, '0, '0, '0);
        // Drop one more than the count, then exactly the count
        offer_request(REQ_TRUNC,  '0, 7'd0, 7'd3);
        offer_request(REQ_TRUNC,  '0, 7'd0, 7'd2);
        offer_request(REQ_INSERT, 64'h8000_0000_0000_0001, 7'd0, 7'd0);
        offer_request(REQ_READ,   '0, MAX_FIELD, 7'd0);
        offer_request(REQ_REMOVE, '0, MAX_FIELD, 7'd0);
        offer_request(REQ_TRUNC,  '0, 7'd0, MAX_FIELD);

        // Random traffic in episodes; the first one uses the growing mix
        mix          = MIX_GROW;
        episode_left = FIRST_EPISODE;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (episode_left == 0)
            begin
                mix          = traffic_mix_t'($urandom_range(2));
                episode_left = $urandom_range(160, 40);
            end
            episode_left--;
            if (n == HOLD_AT)
                hold_off_cycles <= HOLD_OFF_LEN;
            if (n == QUIET_FROM)
                quiet <= 1'b1;
            else if (n == QUIET_TO)
                quiet <= 1'b0;
            random_request(mix);
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then allow the block's latency
        @(posedge clk);
        while (replies_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Covered %0d append, %0d insert, %0d remove, %0d truncate, %0d read requests",
                 kind_sent[REQ_APPEND], kind_sent[REQ_INSERT], kind_sent[REQ_REMOVE],
                 kind_sent[REQ_TRUNC], kind_sent[REQ_READ]);
        $display("plus %0d spare codes; %0d results checked across fill, drain and stall phases",
                 kind_sent[FIRST_SPARE_REQ] + kind_sent[3'(FIRST_SPARE_REQ + 3'd1)]
                 + kind_sent[LAST_SPARE_REQ], replies_checked);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
